// ----- rtl/monochrome_page_framebuffer_top_assert.svh -----
// Assertion macros used by the framebuffer port checker.
`ifndef MONOCHROME_PAGE_FRAMEBUFFER_TOP_ASSERT_SVH
`define MONOCHROME_PAGE_FRAMEBUFFER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("framebuffer port check failed");

// The consequent must hold in the cycle after the antecedent.
`define MPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("framebuffer port check failed");

`endif

// ----- rtl/mpf_pkg.sv -----
// Shared constants and types of the page-organized monochrome framebuffer.
package mpf_pkg;

    // Visible screen size, used to clip pixels.
    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_ROWS    = 64;

    // Store geometry: 8 pages of 128 column bytes, held as 64-bit rows of 8 columns.
    localparam int PAGE_STRIDE  = 128;
    localparam int PAGE_COUNT   = 8;
    localparam int LANE_COUNT   = 8;
    localparam int WORD_COUNT   = PAGE_STRIDE / LANE_COUNT;
    localparam int ROW_COUNT    = PAGE_COUNT * WORD_COUNT;
    localparam int DATA_W       = 64;
    localparam int PAGE_W       = 3;
    localparam int WORD_W       = 4;
    localparam int ROW_ADDR_W   = PAGE_W + WORD_W;
    localparam int COORD_X_W    = 7;
    localparam int COORD_Y_W    = 6;

    // Controller command bytes.
    localparam logic [7:0] OP_SET_PAGE = 8'hB0;
    localparam logic [7:0] OP_COL_LOW  = 8'h00;
    localparam logic [7:0] OP_COL_HIGH = 8'h10;
    localparam logic [7:0] COL_SHIFT   = 8'h04;

    // Byte counts of the two result kinds.
    localparam logic [3:0] CMD_BYTES  = 4'd3;
    localparam logic [3:0] DATA_BYTES = 4'd8;

    // Input actions.
    typedef enum logic [1:0] {
        ACT_PIXEL   = 2'd0,
        ACT_BOX     = 2'd1,
        ACT_OUTLINE = 2'd2,
        ACT_REFRESH = 2'd3
    } t_action;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FLIPPED  = 2'd0;
    localparam t_cfg_idx CFG_REVERSE  = 2'd1;
    localparam t_cfg_idx CFG_TRACKING = 2'd2;

    // Access request from the sequencer to the frame store.
    typedef struct packed {
        logic                  rd_en;
        logic [ROW_ADDR_W-1:0] rd_addr;
        logic                  wr_en;
        logic [ROW_ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0]     wr_data;
    } t_store_req;

endpackage

// ----- rtl/mpf_if.sv -----
// Channel interfaces of the framebuffer: input items, results and configuration.

// Drawing and refresh transactions into the block.
interface mpf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] left_x;
    logic [7:0] top_y;
    logic [7:0] right_x;
    logic [7:0] bottom_y;
    logic       colour;
    logic [2:0] page_index;

    modport source (
        output valid, action, left_x, top_y, right_x, bottom_y, colour, page_index,
        input  ready
    );
    modport sink (
        input  valid, action, left_x, top_y, right_x, bottom_y, colour, page_index,
        output ready
    );
endinterface

// Command and display data transactions out of the block.
interface mpf_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] payload;
    logic [3:0]  byte_count;
    logic        is_command;
    logic        last;

    modport source (
        output valid, payload, byte_count, is_command, last,
        input  ready
    );
    modport sink (
        input  valid, payload, byte_count, is_command, last,
        output ready
    );
endinterface

// Configuration register writes.
interface mpf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- rtl/mpf_store.sv -----
// Frame store: 128 rows of 64 bits with per-row valid bits so reset reads as zero.
module mpf_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mpf_pkg::t_store_req         i_req,
    output logic [mpf_pkg::DATA_W-1:0]  o_rd_data
);
    import mpf_pkg::*;

    logic [DATA_W-1:0]    r_mem [ROW_COUNT];
    logic [ROW_COUNT-1:0] r_row_valid;
    logic [DATA_W-1:0]    r_rd_word;
    logic                 r_rd_valid;

    // Memory array: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_word <= r_mem[i_req.rd_addr];
        end
    end

    // A row never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_row_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_word : '0;

endmodule

// ----- rtl/monochrome_page_framebuffer_top.sv -----
// Top level of the page-organized monochrome framebuffer and its sequencer.
//
// Usage: items arrive on i_in (valid/ready). A pixel write, box clear or
// rectangle outline updates the 128x64 frame store and produces no result.
// A page refresh produces one command transaction (set page, column low,
// column high) and then 16 data transactions of eight column bytes on o_out,
// the last one flagged. Register writes come on i_cfg; the user must send them
// only while the block is idle, as the block itself does not enforce it. The
// store is a synchronous memory of 64-bit rows with one read and one write port,
// used one access at a time, so every row touched is read in ST_RD and then
// written in ST_WR. A pixel write or box is one segment, an outline four; each
// passes ST_SEG, then a read and a write per row of eight columns it covers. A
// refresh loads the command in ST_CMD, then reads each data row in ST_REF_RD and
// loads it in ST_REF_OUT; a refresh of a clean page with tracking on sends nothing.
// Results sit in one output register; a stalled receiver holds the sequencer
// until that register drains, and a new item can be accepted while the last
// result of a refresh waits there.
// Reset clears the configuration, the dirty marks, the output register and
// the row valid bits, so the whole store reads as zero with no clearing pass.
module monochrome_page_framebuffer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mpf_in_if.sink     i_in,
    mpf_out_if.source  o_out,
    mpf_cfg_if.sink    i_cfg
);
    import mpf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_RD,
        ST_WR,
        ST_CMD,
        ST_REF_RD,
        ST_REF_OUT
    } t_state;

    t_state                 r_state;
    t_action                r_action;
    logic [7:0]             r_x1;
    logic [7:0]             r_y1;
    logic [7:0]             r_x2;
    logic [7:0]             r_y2;
    logic                   r_colour;
    logic [PAGE_W-1:0]      r_ref_page;
    logic [1:0]             r_seg;
    logic [PAGE_W-1:0]      r_page;
    logic [WORD_W-1:0]      r_word;
    logic [WORD_W-1:0]      r_k;
    logic                   r_flipped;
    logic                   r_reverse;
    logic                   r_tracking;
    logic [PAGE_COUNT-1:0]  r_dirty;
    logic                   r_out_valid;
    logic [DATA_W-1:0]      r_out_payload;
    logic [3:0]             r_out_count;
    logic                   r_out_cmd;
    logic                   r_out_last;

    logic                   in_fire;
    logic                   out_free;
    logic                   out_load;
    t_action                in_action;
    logic                   x1_on, y1_on, x2_on, y2_on;
    logic [COORD_X_W-1:0]   x2_clip;
    logic [COORD_Y_W-1:0]   y2_clip;
    logic                   seg_valid;
    logic [COORD_X_W-1:0]   seg_xa, seg_xb;
    logic [COORD_Y_W-1:0]   seg_ya, seg_yb;
    logic                   seg_set;
    logic [1:0]             seg_last;
    logic [WORD_W-1:0]      word_lo, word_hi;
    logic [PAGE_W-1:0]      page_hi;
    logic [LANE_COUNT-1:0]  lane_ok;
    logic [7:0]             bit_ok;
    logic [DATA_W-1:0]      wr_mask;
    logic [DATA_W-1:0]      rd_data;
    logic [7:0]             col_low;
    t_store_req             store_req;

    // Handshakes.
    assign in_action   = t_action'(i_in.action);
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign out_load    = out_free && ((r_state == ST_CMD) || (r_state == ST_REF_OUT));
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.payload    = r_out_payload;
    assign o_out.byte_count = r_out_count;
    assign o_out.is_command = r_out_cmd;
    assign o_out.last       = r_out_last;

    // Clipping of the held item's edges against the screen.
    assign x1_on   = (r_x1 < 8'(SCREEN_COLUMNS));
    assign y1_on   = (r_y1 < 8'(SCREEN_ROWS));
    assign x2_on   = (r_x2 < 8'(SCREEN_COLUMNS));
    assign y2_on   = (r_y2 < 8'(SCREEN_ROWS));
    assign x2_clip = x2_on ? r_x2[COORD_X_W-1:0] : COORD_X_W'(SCREEN_COLUMNS - 1);
    assign y2_clip = y2_on ? r_y2[COORD_Y_W-1:0] : COORD_Y_W'(SCREEN_ROWS - 1);

    // Each drawing action is one or more spans: a column range times a row range.
    always_comb begin
        seg_valid = 1'b0;
        seg_xa    = r_x1[COORD_X_W-1:0];
        seg_xb    = r_x1[COORD_X_W-1:0];
        seg_ya    = r_y1[COORD_Y_W-1:0];
        seg_yb    = r_y1[COORD_Y_W-1:0];
        seg_set   = r_colour;
        seg_last  = 2'd0;
        case (r_action)
            ACT_PIXEL: begin
                seg_valid = x1_on && y1_on;
            end
            ACT_BOX: begin
                seg_valid = x1_on && y1_on && x2_on && y2_on
                            && (r_x1 <= r_x2) && (r_y1 <= r_y2);
                seg_xb    = r_x2[COORD_X_W-1:0];
                seg_yb    = r_y2[COORD_Y_W-1:0];
                seg_set   = 1'b0;
            end
            ACT_OUTLINE: begin
                seg_last = 2'd3;
                case (r_seg)
                    2'd0: begin
                        // Top edge.
                        seg_valid = y1_on && x1_on && (r_x1 <= r_x2);
                        seg_xb    = x2_clip;
                    end
                    2'd1: begin
                        // Bottom edge.
                        seg_valid = y2_on && x1_on && (r_x1 <= r_x2);
                        seg_xb    = x2_clip;
                        seg_ya    = r_y2[COORD_Y_W-1:0];
                        seg_yb    = r_y2[COORD_Y_W-1:0];
                    end
                    2'd2: begin
                        // Left edge.
                        seg_valid = x1_on && y1_on && (r_y1 <= r_y2);
                        seg_yb    = y2_clip;
                    end
                    default: begin
                        // Right edge.
                        seg_valid = x2_on && y1_on && (r_y1 <= r_y2);
                        seg_xa    = r_x2[COORD_X_W-1:0];
                        seg_xb    = r_x2[COORD_X_W-1:0];
                        seg_yb    = y2_clip;
                    end
                endcase
            end
            default: begin
                seg_valid = 1'b0;
            end
        endcase
    end

    assign word_lo = seg_xa[COORD_X_W-1:3];
    assign word_hi = seg_xb[COORD_X_W-1:3];
    assign page_hi = seg_yb[COORD_Y_W-1:3];

    // Pixel mask of the current row: columns and rows inside the span.
    always_comb begin
        for (int l = 0; l < LANE_COUNT; l++) begin
            lane_ok[l] = ({r_word, 3'(l)} >= seg_xa) && ({r_word, 3'(l)} <= seg_xb);
        end
        for (int b = 0; b < 8; b++) begin
            bit_ok[b] = ({r_page, 3'(b)} >= seg_ya) && ({r_page, 3'(b)} <= seg_yb);
        end
        for (int l = 0; l < LANE_COUNT; l++) begin
            wr_mask[l*8 +: 8] = lane_ok[l] ? bit_ok : 8'h00;
        end
    end

    // Store accesses driven by the sequencer state.
    always_comb begin
        store_req.rd_en   = (r_state == ST_RD) || (r_state == ST_REF_RD);
        store_req.rd_addr = (r_state == ST_REF_RD) ? {r_ref_page, r_k} : {r_page, r_word};
        store_req.wr_en   = (r_state == ST_WR);
        store_req.wr_addr = {r_page, r_word};
        store_req.wr_data = seg_set ? (rd_data | wr_mask) : (rd_data & ~wr_mask);
    end

    mpf_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    assign col_low = OP_COL_LOW | ((r_flipped ^ r_reverse) ? COL_SHIFT : 8'h00);

    // Item fields held for the duration of the item.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x1       <= i_in.left_x;
            r_y1       <= i_in.top_y;
            r_x2       <= i_in.right_x;
            r_y2       <= i_in.bottom_y;
            r_colour   <= i_in.colour;
            r_ref_page <= i_in.page_index;
        end
    end

    // Sequencer, configuration, dirty marks and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_action      <= ACT_PIXEL;
            r_seg         <= 2'd0;
            r_page        <= '0;
            r_word        <= '0;
            r_k           <= '0;
            r_flipped     <= 1'b0;
            r_reverse     <= 1'b0;
            r_tracking    <= 1'b0;
            r_dirty       <= '0;
            r_out_valid   <= 1'b0;
            r_out_payload <= '0;
            r_out_count   <= '0;
            r_out_cmd     <= 1'b0;
            r_out_last    <= 1'b0;
        end else begin
            // Configuration transactions.
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_FLIPPED:  r_flipped  <= i_cfg.data;
                    CFG_REVERSE:  r_reverse  <= i_cfg.data;
                    CFG_TRACKING: r_tracking <= i_cfg.data;
                    default: ;
                endcase
            end

            // The output register drains when the receiver takes it and nothing new is loaded.
            if (r_out_valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_action <= in_action;
                        r_seg    <= 2'd0;
                        if (in_action == ACT_REFRESH) begin
                            if (!r_tracking || r_dirty[i_in.page_index]) begin
                                if (r_tracking) begin
                                    r_dirty[i_in.page_index] <= 1'b0;
                                end
                                r_state <= ST_CMD;
                            end
                        end else begin
                            r_state <= ST_SEG;
                        end
                    end
                end
                ST_SEG: begin
                    if (seg_valid) begin
                        r_page  <= seg_ya[COORD_Y_W-1:3];
                        r_word  <= word_lo;
                        r_state <= ST_RD;
                    end else if (r_seg == seg_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_seg <= r_seg + 2'd1;
                    end
                end
                ST_RD: begin
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    if (r_tracking) begin
                        r_dirty[r_page] <= 1'b1;
                    end
                    if (r_word != word_hi) begin
                        r_word  <= r_word + 1'b1;
                        r_state <= ST_RD;
                    end else if (r_page != page_hi) begin
                        r_page  <= r_page + 1'b1;
                        r_word  <= word_lo;
                        r_state <= ST_RD;
                    end else if (r_seg == seg_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_seg   <= r_seg + 2'd1;
                        r_state <= ST_SEG;
                    end
                end
                ST_CMD: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_payload <= {40'd0, OP_COL_HIGH, col_low,
                                          OP_SET_PAGE | {5'd0, r_ref_page}};
                        r_out_count   <= CMD_BYTES;
                        r_out_cmd     <= 1'b1;
                        r_out_last    <= 1'b0;
                        r_k           <= '0;
                        r_state       <= ST_REF_RD;
                    end
                end
                ST_REF_RD: begin
                    r_state <= ST_REF_OUT;
                end
                ST_REF_OUT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_payload <= rd_data;
                        r_out_count   <= DATA_BYTES;
                        r_out_cmd     <= 1'b0;
                        r_out_last    <= &r_k;
                        if (&r_k) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_REF_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/mpf_checker.sv -----
// Port-level checks of the framebuffer top level and their bind statement.
module mpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_payload,
    input logic [3:0]  i_byte_count,
    input logic        i_is_command,
    input logic        i_last
);
    import mpf_pkg::*;

    `include "monochrome_page_framebuffer_top_assert.svh"

    // A result the receiver stalls stays offered unchanged.
    `MPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_payload) && $stable(i_byte_count) && $stable(i_is_command) && $stable(i_last))

    // Commands carry three bytes and never end a refresh; data carries eight.
    `MPF_ASSERT_NOW(a_out_kind, i_clk, i_rst_n, i_out_valid, (i_is_command && i_byte_count == CMD_BYTES && !i_last) || (!i_is_command && i_byte_count == DATA_BYTES))

    // A command transaction is followed by data, never a second command.
    `MPF_ASSERT_NEXT(a_cmd_then_data, i_clk, i_rst_n, i_out_valid && i_out_ready && i_is_command, !(i_out_valid && i_is_command))

    // While a refresh is still sending, no new item is taken.
    `MPF_ASSERT_NOW(a_busy_refresh, i_clk, i_rst_n, i_out_valid && !i_is_command && !i_last, !i_in_ready)

endmodule

bind monochrome_page_framebuffer_top mpf_checker u_mpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_payload    (o_out.payload),
    .i_byte_count (o_out.byte_count),
    .i_is_command (o_out.is_command),
    .i_last       (o_out.last)
);

// ----- test/framebuffer_checker.sv -----
// Watches the framebuffer channels, tracks a shadow copy of the screen and checks every result.
module framebuffer_checker
    import mpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mpf_in_if    in_ch,
    mpf_out_if   out_ch,
    mpf_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_items,
    output int   o_beats,
    output int   o_page_sends,
    output int   o_page_skips
);
    timeunit 1ns;
    timeprecision 1ps;

    // One transaction on the result channel.
    typedef struct packed {
        logic [63:0] payload;
        logic [3:0]  byte_count;
        logic        is_command;
        logic        last;
    } t_beat;

    // Shadow of the frame store, the dirty marks and the mode bits.
    logic [7:0] shadow_fb [PAGE_COUNT*PAGE_STRIDE] = '{default: 8'h00};
    logic [7:0] dirty_pages = 8'h00;
    logic       flip_q      = 1'b0;
    logic       rev_q       = 1'b0;
    logic       track_q     = 1'b0;

    // Result transactions still owed by the block, oldest first.
    t_beat page_beats_due [$];

    int fail_count = 0;
    int pending_q  = 0;
    int item_count = 0;
    int beat_count = 0;
    int send_count = 0;
    int skip_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_q;
    assign o_items      = item_count;
    assign o_beats      = beat_count;
    assign o_page_sends = send_count;
    assign o_page_skips = skip_count;

    // Set or clear one pixel; pixels off the visible screen are dropped.
    function automatic void plot_pixel(int x, int y, logic on);
        int addr;
        if (x >= SCREEN_COLUMNS || y >= SCREEN_ROWS) begin
            return;
        end
        addr = (y / 8) * PAGE_STRIDE + x;
        if (track_q) begin
            dirty_pages[y / 8] = 1'b1;
        end
        shadow_fb[addr][y % 8] = on;
    endfunction

    // Clear a box; a box with an edge off screen or inverted edges does nothing.
    function automatic void clear_box(int x1, int y1, int x2, int y2);
        if (x1 >= SCREEN_COLUMNS || x2 >= SCREEN_COLUMNS || y1 >= SCREEN_ROWS ||
            y2 >= SCREEN_ROWS || x1 > x2 || y1 > y2) begin
            return;
        end
        for (int y = y1; y <= y2; y++) begin
            for (int x = x1; x <= x2; x++) begin
                plot_pixel(x, y, 1'b0);
            end
        end
    endfunction

    // Rectangle outline with every pixel clipped on its own.
    function automatic void draw_outline(int x1, int y1, int x2, int y2, logic on);
        for (int x = x1; x <= x2; x++) begin
            plot_pixel(x, y1, on);
            plot_pixel(x, y2, on);
        end
        for (int y = y1; y <= y2; y++) begin
            plot_pixel(x1, y, on);
            plot_pixel(x2, y, on);
        end
    endfunction

    // Queue a page's command and sixteen data transactions; tracking skips a clean page.
    function automatic void emit_page(logic [2:0] page);
        t_beat      beat;
        logic [7:0] col_low;
        if (track_q) begin
            if (!dirty_pages[page]) begin
                skip_count++;
                return;
            end
            dirty_pages[page] = 1'b0;
        end
        send_count++;
        col_low = OP_COL_LOW | ((flip_q ^ rev_q) ? COL_SHIFT : 8'h00);
        beat.payload    = {40'd0, OP_COL_HIGH, col_low, OP_SET_PAGE | {5'd0, page}};
        beat.byte_count = CMD_BYTES;
        beat.is_command = 1'b1;
        beat.last       = 1'b0;
        page_beats_due.push_back(beat);
        for (int w = 0; w < WORD_COUNT; w++) begin
            for (int lane = 0; lane < LANE_COUNT; lane++) begin
                beat.payload[8*lane +: 8] = shadow_fb[page*PAGE_STRIDE + w*LANE_COUNT + lane];
            end
            beat.byte_count = DATA_BYTES;
            beat.is_command = 1'b0;
            beat.last       = (w == WORD_COUNT - 1);
            page_beats_due.push_back(beat);
        end
    endfunction

    // Report one field that differs from the prediction.
    function automatic void report_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: result %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    // Compare results, follow register writes and predict accepted items.
    always @(posedge i_clk) begin
        t_beat due;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                beat_count++;
                if (page_beats_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual payload %h",
                             $time, out_ch.payload);
                    fail_count++;
                end else begin
                    due = page_beats_due.pop_front();
                    report_field("payload", due.payload, out_ch.payload);
                    report_field("byte_count", 64'(due.byte_count), 64'(out_ch.byte_count));
                    report_field("is_command", 64'(due.is_command), 64'(out_ch.is_command));
                    report_field("last", 64'(due.last), 64'(out_ch.last));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_FLIPPED:  flip_q  = cfg_ch.data;
                    CFG_REVERSE:  rev_q   = cfg_ch.data;
                    CFG_TRACKING: track_q = cfg_ch.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                item_count++;
                case (t_action'(in_ch.action))
                    ACT_PIXEL:   plot_pixel(in_ch.left_x, in_ch.top_y, in_ch.colour);
                    ACT_BOX:     clear_box(in_ch.left_x, in_ch.top_y,
                                           in_ch.right_x, in_ch.bottom_y);
                    ACT_OUTLINE: draw_outline(in_ch.left_x, in_ch.top_y,
                                              in_ch.right_x, in_ch.bottom_y, in_ch.colour);
                    default:     emit_page(in_ch.page_index);
                endcase
            end
        end
        pending_q <= page_beats_due.size();
    end

endmodule

// ----- test/testbench.sv -----
// Stimulus, clock, reset and verdict for the monochrome page framebuffer.
module testbench;
    import mpf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles allowed for a drawing item to finish after its acceptance.
    localparam int SETTLE_CYCLES = 400;
    // Cycles without any transaction before the run is abandoned.
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_ITEMS  = 100;
    localparam int PHASE_ITEMS   = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n;

    mpf_in_if  in_ch ();
    mpf_out_if out_ch ();
    mpf_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int item_count;
    int beat_count;
    int send_count;
    int skip_count;
    int idle_cycles = 0;

    logic calm_tx = 1'b0;
    logic calm_rx = 1'b0;

    monochrome_page_framebuffer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    framebuffer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_items      (item_count),
        .o_beats      (beat_count),
        .o_page_sends (send_count),
        .o_page_skips (skip_count)
    );

    always #2ns i_clk = ~i_clk;

    // Abandon the run when no channel has moved a transaction for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result receiver: random stalls before each transaction, with calm stretches.
    initial begin
        int stall;
        int taken;
        taken = 0;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            stall = calm_rx ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            taken++;
            if (taken % 40 == 0) begin
                calm_rx = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Offer one item after a random gap and hold it until the block takes it.
    task automatic send_item(input t_action act, input logic [7:0] lx, ty, rx, by,
                             input logic col, input logic [2:0] pg);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.left_x     <= lx;
        in_ch.top_y      <= ty;
        in_ch.right_x    <= rx;
        in_ch.bottom_y   <= by;
        in_ch.colour     <= col;
        in_ch.page_index <= pg;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // Stop offering items and wait until every predicted result has arrived.
    task automatic wait_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Hold one register write until it is taken; valid stays up for the next one.
    task automatic write_reg(input t_cfg_idx idx, input logic value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    // Write all three mode registers once the block has gone idle.
    task automatic set_mode(input logic flip, input logic rev, input logic track);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_FLIPPED, flip);
        write_reg(CFG_REVERSE, rev);
        write_reg(CFG_TRACKING, track);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly visible coordinates, sometimes anything the field holds.
    function automatic logic [7:0] pick_x();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] pick_y();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 63));
    endfunction

    // One random item: mostly pixels and refreshes, boxes and outlines mostly well formed.
    task automatic send_random_item();
        int         pick;
        int         span;
        logic [7:0] lx, ty, rx, by;
        pick = $urandom_range(0, 99);
        lx = pick_x();
        ty = pick_y();
        rx = 8'($urandom_range(0, 255));
        by = 8'($urandom_range(0, 255));
        if (pick < 40) begin
            send_item(ACT_PIXEL, lx, ty, rx, by, 1'($urandom), 3'($urandom));
        end else if (pick < 55) begin
            if ($urandom_range(0, 4) != 0) begin
                lx = 8'($urandom_range(0, 127));
                ty = 8'($urandom_range(0, 63));
                span = lx + $urandom_range(0, 15);
                rx = (span > 127) ? 8'd127 : 8'(span);
                span = ty + $urandom_range(0, 10);
                by = (span > 63) ? 8'd63 : 8'(span);
            end
            send_item(ACT_BOX, lx, ty, rx, by, 1'($urandom), 3'($urandom));
        end else if (pick < 70) begin
            if ($urandom_range(0, 4) != 0) begin
                span = lx + $urandom_range(0, 24);
                rx = (span > 255) ? 8'd255 : 8'(span);
                span = ty + $urandom_range(0, 12);
                by = (span > 255) ? 8'd255 : 8'(span);
            end
            send_item(ACT_OUTLINE, lx, ty, rx, by, 1'($urandom), 3'($urandom));
        end else begin
            send_item(ACT_REFRESH, lx, ty, rx, by, 1'($urandom), 3'($urandom));
        end
    endtask

    // Reset, directed items, random phases under changing modes, then the verdict.
    initial begin
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.action        <= ACT_PIXEL;
        in_ch.left_x        <= 8'd0;
        in_ch.top_y         <= 8'd0;
        in_ch.right_x       <= 8'd0;
        in_ch.bottom_y      <= 8'd0;
        in_ch.colour        <= 1'b0;
        in_ch.page_index    <= 3'd0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_FLIPPED;
        cfg_ch.data         <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pixels at the corners and just off the screen.
        send_item(ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 3'd0);
        send_item(ACT_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, 3'd0);
        send_item(ACT_PIXEL, 8'd128, 8'd5, 8'd0, 8'd0, 1'b1, 3'd7);
        send_item(ACT_PIXEL, 8'd5, 8'd64, 8'd0, 8'd0, 1'b1, 3'd7);
        send_item(ACT_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 3'd7);
        send_item(ACT_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b0, 3'd0);
        // Outlines: full border, clipped walk to the field limit, and inverted edges.
        send_item(ACT_OUTLINE, 8'd0, 8'd0, 8'd127, 8'd63, 1'b1, 3'd0);
        send_item(ACT_OUTLINE, 8'd120, 8'd60, 8'd255, 8'd255, 1'b1, 3'd0);
        send_item(ACT_OUTLINE, 8'd10, 8'd20, 8'd5, 8'd30, 1'b1, 3'd0);
        send_item(ACT_OUTLINE, 8'd10, 8'd30, 8'd20, 8'd5, 1'b1, 3'd0);
        // Boxes: one valid, then inverted and off-screen ones that are ignored.
        send_item(ACT_BOX, 8'd1, 8'd1, 8'd126, 8'd62, 1'b0, 3'd0);
        send_item(ACT_BOX, 8'd50, 8'd10, 8'd40, 8'd20, 1'b0, 3'd0);
        send_item(ACT_BOX, 8'd0, 8'd0, 8'd128, 8'd10, 1'b0, 3'd0);
        send_item(ACT_BOX, 8'd0, 8'd30, 8'd127, 8'd20, 1'b0, 3'd0);
        // Refreshes with tracking off always send the page.
        send_item(ACT_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0);
        send_item(ACT_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd3);
        send_item(ACT_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7);

        // Tracking on: clean pages are skipped, dirty ones are sent once.
        set_mode(1'b1, 1'b0, 1'b1);
        send_item(ACT_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd2);
        send_item(ACT_PIXEL, 8'd3, 8'd17, 8'd0, 8'd0, 1'b1, 3'd0);
        send_item(ACT_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd2);
        send_item(ACT_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd2);
        send_item(ACT_BOX, 8'd0, 8'd40, 8'd127, 8'd47, 1'b0, 3'd0);
        send_item(ACT_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd5);
        // Flipped and reversed cancel out in the column offset.
        set_mode(1'b1, 1'b1, 1'b0);
        send_item(ACT_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0);
        set_mode(1'b0, 1'b1, 1'b1);
        send_item(ACT_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7);

        // Random phases, each under its own mode; the first two are the extremes.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                if (n == 0) begin
                    set_mode(1'b1, 1'b1, 1'b1);
                end else if (n == PHASE_ITEMS) begin
                    set_mode(1'b0, 1'b0, 1'b0);
                end else begin
                    set_mode(1'($urandom), 1'($urandom), 1'($urandom));
                end
                calm_tx = ($urandom_range(0, 3) == 0);
            end else if (n % PHASE_ITEMS == PHASE_ITEMS / 2) begin
                wait_results();
            end
            send_random_item();
        end

        // Let the last results drain and the last drawing item finish.
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d result transactions checked, %0d pages sent,",
                 item_count, beat_count, send_count);
        $display("%0d clean-page refreshes skipped, under several mode settings.", skip_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mpf_pkg.sv
rtl/mpf_if.sv
rtl/mpf_store.sv
rtl/monochrome_page_framebuffer_top.sv
rtl/mpf_checker.sv
test/framebuffer_checker.sv
test/testbench.sv
